@@ rtl/core/spd_pkg.sv @@
// Shared types and constants for the serial packet deframer.
package spd_pkg;

    localparam logic [7:0] SYNC_FIRST   = 8'hAA;
    localparam logic [7:0] SYNC_SECOND  = 8'h55;
    localparam logic [7:0] BCAST_ID     = 8'd250;
    localparam logic [7:0] OWN_ID_RESET = 8'd24;

    // Frame position: which byte of the packet is expected next.
    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_ID    = 4'd2,
        PH_TYPE  = 4'd3,
        PH_D1    = 4'd4,
        PH_D2    = 4'd5,
        PH_D3    = 4'd6,
        PH_D4    = 4'd7,
        PH_SEQ   = 4'd8,
        PH_CHECK = 4'd9
    } phase_t;

    typedef struct packed {
        logic       packet_ok;
        logic       checksum_bad;
        logic [7:0] dest_id;
        logic [7:0] pkt_type;
        logic [7:0] data_one;
        logic [7:0] data_two;
        logic [7:0] data_three;
        logic [7:0] data_four;
        logic [7:0] seq_number;
        logic [7:0] check_byte;
    } result_t;

endpackage

@@ rtl/core/spd_if.sv @@
// Handshake channel interfaces for the serial packet deframer.
interface spd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface spd_res_if;
    logic            valid;
    logic            ready;
    spd_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] own_id;

    modport source (output valid, output own_id, input ready);
    modport sink (input valid, input own_id, output ready);
endinterface

@@ rtl/core/serial_packet_deframer.sv @@
// Serial packet deframer: sync hunt, field capture, XOR check, one result per byte.
// A result is registered in the result register, or in the skid while that is held.
// Throughput: one byte per cycle while the skid is empty; the frame tracker and
// checksum are a single registered pass, and a two-entry output (result register
// plus skid) keeps rx ready while one result waits downstream.
// Reset (rst_n, async, active low): hunting the first sync byte, held fields and
// last sequence zero, own ID 24, output empty.
module serial_packet_deframer (
    input  logic       clk,
    input  logic       rst_n,
    spd_cfg_if.sink    cfg,
    spd_rx_if.sink     rx,
    spd_res_if.source  res
);

    // Configured node address.
    logic [7:0] own_id_reg;

    // Frame tracker state.
    spd_pkg::phase_t phase_reg;
    spd_pkg::phase_t phase_next;
    logic [7:0]      held_id_reg;
    logic [7:0]      held_id_next;
    logic [7:0]      held_type_reg;
    logic [7:0]      held_type_next;
    logic [3:0][7:0] held_data_reg;
    logic [3:0][7:0] held_data_next;
    logic [7:0]      last_seq_reg;
    logic [7:0]      last_seq_next;

    // Output register and skid stage.
    spd_pkg::result_t result_next;
    spd_pkg::result_t out_data_reg;
    spd_pkg::result_t skid_data_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    logic       in_fire;
    logic       out_fire;
    logic [7:0] b;
    logic [7:0] sum;
    logic       good;

    // The user must write config only while idle; the block does not enforce this and always takes it.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg <= spd_pkg::OWN_ID_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            own_id_reg <= cfg.own_id;
        end
    end

    // Handshakes. rx stays ready unless the skid stage is occupied.
    assign rx.ready  = !skid_valid_reg;
    assign in_fire   = rx.valid && rx.ready;
    assign out_fire  = res.valid && res.ready;
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;

    assign b = rx.rx_byte;

    // Checksum over sync header through sequence byte; last_seq_reg already
    // holds this packet's sequence byte when the check byte arrives.
    assign sum = spd_pkg::SYNC_FIRST ^ spd_pkg::SYNC_SECOND ^ held_id_reg
               ^ held_type_reg ^ held_data_reg[0] ^ held_data_reg[1]
               ^ held_data_reg[2] ^ held_data_reg[3] ^ last_seq_reg;
    assign good = (sum == b);

    // Next frame position.
    always_comb
    begin
        unique case (phase_reg)
            spd_pkg::PH_SYNC2:
                phase_next = (b == spd_pkg::SYNC_SECOND) ? spd_pkg::PH_ID
                                                          : spd_pkg::PH_HUNT;
            spd_pkg::PH_ID:
                phase_next = (b == own_id_reg || b == spd_pkg::BCAST_ID)
                           ? spd_pkg::PH_TYPE : spd_pkg::PH_HUNT;
            spd_pkg::PH_TYPE:  phase_next = spd_pkg::PH_D1;
            spd_pkg::PH_D1:    phase_next = spd_pkg::PH_D2;
            spd_pkg::PH_D2:    phase_next = spd_pkg::PH_D3;
            spd_pkg::PH_D3:    phase_next = spd_pkg::PH_D4;
            spd_pkg::PH_D4:    phase_next = spd_pkg::PH_SEQ;
            spd_pkg::PH_SEQ:
                // repeated sequence number drops the packet
                phase_next = (b != last_seq_reg) ? spd_pkg::PH_CHECK
                                                 : spd_pkg::PH_HUNT;
            spd_pkg::PH_CHECK: phase_next = spd_pkg::PH_HUNT;
            // hunting, and any unused code: look for the first sync byte
            default:
                phase_next = (b == spd_pkg::SYNC_FIRST) ? spd_pkg::PH_SYNC2
                                                        : spd_pkg::PH_HUNT;
        endcase
    end

    // Field capture and the result for this byte.
    always_comb
    begin
        held_id_next   = held_id_reg;
        held_type_next = held_type_reg;
        held_data_next = held_data_reg;
        last_seq_next  = last_seq_reg;
        result_next    = '0;
        unique case (phase_reg)
            spd_pkg::PH_ID:   held_id_next      = b;
            spd_pkg::PH_TYPE: held_type_next    = b;
            spd_pkg::PH_D1:   held_data_next[0] = b;
            spd_pkg::PH_D2:   held_data_next[1] = b;
            spd_pkg::PH_D3:   held_data_next[2] = b;
            spd_pkg::PH_D4:   held_data_next[3] = b;
            spd_pkg::PH_SEQ:
            begin
                // stored even if the checksum later fails
                if (b != last_seq_reg)
                begin
                    last_seq_next = b;
                end
            end
            spd_pkg::PH_CHECK:
            begin
                result_next.packet_ok    = good;
                result_next.checksum_bad = !good;
                result_next.dest_id      = held_id_reg;
                result_next.pkt_type     = held_type_reg;
                result_next.data_one     = held_data_reg[0];
                result_next.data_two     = held_data_reg[1];
                result_next.data_three   = held_data_reg[2];
                result_next.data_four    = held_data_reg[3];
                result_next.seq_number   = last_seq_reg;
                result_next.check_byte   = b;
                // good broadcast: report as addressed to us, keep check consistent
                if (good && held_id_reg == spd_pkg::BCAST_ID)
                begin
                    result_next.dest_id    = own_id_reg;
                    result_next.check_byte = b ^ spd_pkg::BCAST_ID ^ own_id_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Frame control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= spd_pkg::PH_HUNT;
            last_seq_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            last_seq_reg <= last_seq_next;
        end
    end

    // Captured fields: always written before a packet can complete.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_id_reg   <= 8'd0;
            held_type_reg <= 8'd0;
            held_data_reg <= '0;
        end
        else if (in_fire)
        begin
            held_id_reg   <= held_id_next;
            held_type_reg <= held_type_next;
            held_data_reg <= held_data_next;
        end
    end

    // Output/skid valid flags. Skid fills only when the result register is
    // full and not drained this cycle; it empties into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (in_fire && (!out_valid_reg || out_fire))
        begin
            out_data_reg <= result_next;
        end
        if (in_fire && out_valid_reg && !out_fire)
        begin
            skid_data_reg <= result_next;
        end
    end

endmodule
